// File: rtl/famdc_pkg.sv
// shared types for the floating-point add/mul/div/compare unit
// no dependencies
package famdc_pkg;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_CMP = 3'd4
   } action_type;

   typedef struct packed {
      logic greater;
      logic less;
      logic equal;
      logic unordered;
   } cmp_flags_type;

endpackage

// File: rtl/famdc_divider.sv
// pipelined restoring mantissa divider, one quotient bit per stage
// quotient = floor(num * 2^(MANT_BITS-1) / den), all ones when den is zero
// standalone, no package dependencies
module famdc_divider #(
   parameter int MANT_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [MANT_BITS-1:0]     num,
   input  logic [MANT_BITS-1:0]     den,
   output logic                     out_valid,
   output logic [2*MANT_BITS-2:0]   quot
);

   localparam int M     = MANT_BITS;
   localparam int STEPS = 2 * M - 1;

   logic           vld_ff [STEPS];
   logic [M-1:0]   rem_ff [STEPS];
   logic [M-1:0]   num_ff [STEPS];
   logic [M-1:0]   den_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];

   logic [M-1:0]   rem_in [STEPS];
   logic [STEPS-1:0] quo_in [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic           vld_p;
      logic [M-1:0]   rem_p;
      logic [M-1:0]   num_p;
      logic [M-1:0]   den_p;
      logic [STEPS-1:0] quo_p;
      logic           nbit;
      logic [M:0]     trial;
      logic [M:0]     diff;
      logic           ge;

      if (k == 0) begin : g_first
         assign vld_p = in_valid;
         assign rem_p = '0;
         assign num_p = num;
         assign den_p = den;
         assign quo_p = '0;
      end else begin : g_next
         assign vld_p = vld_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign num_p = num_ff[k-1];
         assign den_p = den_ff[k-1];
         assign quo_p = quo_ff[k-1];
      end

      // numerator bits beyond the mantissa are the appended zeros
      if (k < M) begin : g_nbit
         assign nbit = num_p[M-1-k];
      end else begin : g_zbit
         assign nbit = 1'b0;
      end

      always_comb begin
         trial     = {rem_p, nbit};
         diff      = trial - {1'b0, den_p};
         ge        = trial >= {1'b0, den_p};
         rem_in[k] = ge ? diff[M-1:0] : trial[M-1:0];
         quo_in[k] = quo_p;
         quo_in[k][STEPS-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         num_ff[k] <= num_p;
         den_ff[k] <= den_p;
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign quot      = quo_ff[STEPS-1];

`ifndef SYNTHESIS
   a_lat: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##STEPS out_valid)
      else $error("divider beat lost in pipeline");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      (out_valid && den_ff[STEPS-1] != '0) |-> (rem_ff[STEPS-1] < den_ff[STEPS-1]))
      else $error("divider remainder not below divisor");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      (out_valid && den_ff[STEPS-1] == '0) |-> (quot == '1))
      else $error("zero divisor quotient not all ones");
`endif

endmodule

// File: rtl/float_add_mul_div_compare_unit.sv
// after start is taken, a beat passes stage 1, the divider, stages 4 and 5 and the output register
// throughput: one operation per cycle, any mix of actions; busy is low outside reset
// the divider yields one quotient bit per stage; the side data rides stages 2, 3 and a delay line
// reset: synchronous, active high, clears all valid bits; in-flight beats are dropped
// the receiver cannot stall: each result shows for exactly one cycle on rsp_valid
module float_add_mul_div_compare_unit #(
   parameter int EXP_BITS  = 8,
   parameter int MANT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_action,
   input  logic                  req_lhs_sign,
   input  logic [EXP_BITS-1:0]   req_lhs_exp,
   input  logic [MANT_BITS-1:0]  req_lhs_mant,
   input  logic                  req_rhs_sign,
   input  logic [EXP_BITS-1:0]   req_rhs_exp,
   input  logic [MANT_BITS-1:0]  req_rhs_mant,
   output logic                  rsp_valid,
   output logic                  rsp_result_sign,
   output logic [EXP_BITS-1:0]   rsp_result_exp,
   output logic [MANT_BITS-1:0]  rsp_result_mant,
   output logic                  rsp_greater,
   output logic                  rsp_less,
   output logic                  rsp_equal,
   output logic                  rsp_unordered
);

   import famdc_pkg::*;

   localparam int E       = EXP_BITS;
   localparam int M       = MANT_BITS;
   localparam int H       = (M + 1) / 2;    // low half of a mantissa for the partial products
   localparam int HW      = M - H;
   localparam int QW      = 2 * M - 1;      // quotient width
   localparam int DIV_LAT = QW;
   localparam int DLY     = DIV_LAT - 2;    // depth of the delay line for side data after the product sum
   localparam int LAT     = DIV_LAT + 4;
   localparam int UW      = E + 2;          // signed unbiased exponent width
   localparam int LZW     = $clog2(M + 1);
   localparam int SW      = (E > LZW) ? E : LZW;

   localparam logic [E-1:0] SPEC = {E{1'b1}};
   localparam logic [E-1:0] BIAS = {1'b0, {(E-1){1'b1}}};
   localparam logic [M-1:0] QNAN = {2'b01, {(M-2){1'b0}}};

   // what every action still needs after the first compute stage
   typedef struct packed {
      logic [2:0]    act;
      logic          sx;
      logic          add_sign;
      logic [M-1:0]  add_mag;
      logic [E:0]    add_e;
      logic          add_pass;
      logic          pass_sign;
      logic [E-1:0]  pass_e;
      logic [M-1:0]  pass_m;
      logic          mul_ovf;
      logic [UW-1:0] mul_u;
      logic [UW-1:0] div_u;
      logic          any_nan;
      logic          any_inf;
      logic          any_zero;
      logic          a_inf;
      logic          a_zero;
      logic          b_inf;
      logic          b_zero;
      logic          dz;
      cmp_flags_type cmp;
   } side_type;

   typedef struct packed {
      logic [2*H-1:0]  ll;
      logic [M-1:0]    lh;
      logic [M-1:0]    hl;
      logic [2*HW-1:0] hh;
   } pprod_type;

   typedef struct packed {
      side_type     side;
      logic [M-1:0] pm;
   } mid_type;

   // result before normalization: either final or still to be left-justified
   typedef struct packed {
      logic          fin;
      logic          sign;
      logic [E-1:0]  fin_e;
      logic [M-1:0]  fin_m;
      logic [E-1:0]  nrm_e;
      logic [M-1:0]  nrm_m;
      logic          zfix;
      cmp_flags_type cmp;
   } post_type;

   // ---------------------------------------------------------------- stage 1: capture
   logic          s1_vld_ff;
   logic [2:0]    s1_act_ff;
   logic          s1_as_ff, s1_bs_ff;
   logic [E-1:0]  s1_ae_ff, s1_be_ff;
   logic [M-1:0]  s1_am_ff, s1_bm_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_act_ff <= req_action;
      s1_as_ff  <= req_lhs_sign;
      s1_ae_ff  <= req_lhs_exp;
      s1_am_ff  <= req_lhs_mant;
      s1_bs_ff  <= req_rhs_sign;
      s1_be_ff  <= req_rhs_exp;
      s1_bm_ff  <= req_rhs_mant;
   end

   // ---------------------------------------------------------------- divider
   logic          div_vld;
   logic [QW-1:0] div_q;

   famdc_divider #(
      .MANT_BITS (M)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .num       (s1_am_ff),
      .den       (s1_bm_ff),
      .out_valid (div_vld),
      .quot      (div_q)
   );

   // ---------------------------------------------------------------- stage 2: align/add, decode
   function automatic logic ord_gt(input logic sa, input logic [E-1:0] ea,
                                   input logic [M-1:0] ma, input logic sb,
                                   input logic [E-1:0] eb, input logic [M-1:0] mb);
      logic mag_gt;
      logic mag_lt;
      mag_gt = (ea > eb) || (ea == eb && ma > mb);
      mag_lt = (ea < eb) || (ea == eb && ma < mb);
      if (sa != sb) begin
         return sb;
      end
      return sa ? mag_lt : mag_gt;
   endfunction

   side_type  s2_in, s2_ff;
   pprod_type pp_in, pp_ff;
   logic      s2_vld_ff;

   always_comb begin
      logic          a_spec, b_spec, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic          bs_eff, swap, big_s, lit_s, carry, sgn, nan, bz, same;
      logic [E-1:0]  big_e, lit_e, d;
      logic [M-1:0]  big_m, lit_m, lm, mag;
      logic [M:0]    sum;
      logic [UW-1:0] msum;
      logic [H-1:0]  al, bl;
      logic [HW-1:0] ah, bh;

      a_spec = s1_ae_ff == SPEC;
      b_spec = s1_be_ff == SPEC;
      a_nan  = a_spec && s1_am_ff != '0;
      b_nan  = b_spec && s1_bm_ff != '0;
      a_inf  = a_spec && s1_am_ff == '0;
      b_inf  = b_spec && s1_bm_ff == '0;
      a_zero = s1_ae_ff == '0 && s1_am_ff == '0;
      b_zero = s1_be_ff == '0 && s1_bm_ff == '0;

      // add and subtract: align the smaller exponent, then add or subtract magnitudes
      bs_eff = s1_bs_ff ^ (s1_act_ff == ACT_SUB);
      swap   = s1_ae_ff < s1_be_ff;
      big_s  = swap ? bs_eff   : s1_as_ff;
      big_e  = swap ? s1_be_ff : s1_ae_ff;
      big_m  = swap ? s1_bm_ff : s1_am_ff;
      lit_s  = swap ? s1_as_ff : bs_eff;
      lit_e  = swap ? s1_ae_ff : s1_be_ff;
      lit_m  = swap ? s1_am_ff : s1_bm_ff;
      d      = big_e - lit_e;
      lm     = lit_m >> d;
      sum    = {1'b0, big_m} + {1'b0, lm};
      carry  = 1'b0;
      if (big_s == lit_s) begin
         carry = sum[M];
         mag   = carry ? {1'b1, sum[M-1:1]} : sum[M-1:0];
         sgn   = big_s;
      end else if (big_m >= lm) begin
         mag = big_m - lm;
         sgn = big_s;
      end else begin
         mag = lm - big_m;
         sgn = lit_s;
      end
      if (mag == '0) begin
         sgn = 1'b0;
      end

      s2_in.act       = s1_act_ff;
      s2_in.sx        = s1_as_ff ^ s1_bs_ff;
      s2_in.add_sign  = sgn;
      s2_in.add_mag   = mag;
      s2_in.add_e     = {1'b0, big_e} + {{E{1'b0}}, carry};
      // a special operand passes straight through, the first one wins
      s2_in.add_pass  = a_spec || b_spec;
      s2_in.pass_sign = a_spec ? s1_as_ff : bs_eff;
      s2_in.pass_e    = a_spec ? s1_ae_ff : s1_be_ff;
      s2_in.pass_m    = a_spec ? s1_am_ff : s1_bm_ff;

      msum            = {2'b00, s1_ae_ff} + {2'b00, s1_be_ff};
      s2_in.mul_ovf   = msum >= ({2'b00, SPEC} + {2'b00, BIAS});
      s2_in.mul_u     = msum - {2'b00, BIAS};
      s2_in.div_u     = {2'b00, s1_ae_ff} - {2'b00, s1_be_ff} + {2'b00, BIAS}
                        + {{(UW-1){1'b0}}, 1'b1};

      s2_in.any_nan   = a_nan || b_nan;
      s2_in.any_inf   = a_inf || b_inf;
      s2_in.any_zero  = a_zero || b_zero;
      s2_in.a_inf     = a_inf;
      s2_in.a_zero    = a_zero;
      s2_in.b_inf     = b_inf;
      s2_in.b_zero    = b_zero;
      s2_in.dz        = s1_bm_ff == '0;

      // compare flags, only for the compare action
      nan  = a_nan || b_nan;
      bz   = a_zero && b_zero;
      same = s1_as_ff == s1_bs_ff && s1_ae_ff == s1_be_ff && s1_am_ff == s1_bm_ff;
      s2_in.cmp = '0;
      if (s1_act_ff == ACT_CMP) begin
         s2_in.cmp.greater   = !nan && !bz && ord_gt(s1_as_ff, s1_ae_ff, s1_am_ff,
                                                      s1_bs_ff, s1_be_ff, s1_bm_ff);
         s2_in.cmp.less      = !nan && !bz && ord_gt(s1_bs_ff, s1_be_ff, s1_bm_ff,
                                                      s1_as_ff, s1_ae_ff, s1_am_ff);
         s2_in.cmp.equal     = bz || (!nan && same);
         s2_in.cmp.unordered = nan;
      end

      // multiply: four half-width partial products
      al    = s1_am_ff[H-1:0];
      ah    = s1_am_ff[M-1:H];
      bl    = s1_bm_ff[H-1:0];
      bh    = s1_bm_ff[M-1:H];
      pp_in.ll = al * bl;
      pp_in.lh = al * bh;
      pp_in.hl = ah * bl;
      pp_in.hh = ah * bh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      pp_ff <= pp_in;
   end

   // ---------------------------------------------------------------- stage 3: product sum
   mid_type s3_in, s3_ff;
   logic    s3_vld_ff;

   always_comb begin
      logic [2*M-1:0] prod;
      prod = (2*M)'(pp_ff.ll)
           + ((2*M)'(pp_ff.lh) << H)
           + ((2*M)'(pp_ff.hl) << H)
           + ((2*M)'(pp_ff.hh) << (2*H));
      s3_in.side = s2_ff;
      s3_in.pm   = prod[2*M-1:M];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
   end

   // ---------------------------------------------------------------- delay line to meet the quotient
   mid_type dly_ff     [DLY];
   logic    dly_vld_ff [DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            dly_vld_ff[i] <= 1'b0;
         end
      end else begin
         dly_vld_ff[0] <= s3_vld_ff;
         for (int i = 1; i < DLY; i++) begin
            dly_vld_ff[i] <= dly_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dly_ff[0] <= s3_ff;
      for (int i = 1; i < DLY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- stage 4: merge and special cases
   post_type s4_in, s4_ff;
   logic     s4_vld_ff;

   always_comb begin
      side_type      sd;
      logic [M-1:0]  pm;
      logic [UW-1:0] su;
      logic [M-1:0]  dz_m;
      logic [QW-1:0] qs;
      logic [M-1:0]  pms;

      sd = dly_ff[DLY-1].side;
      pm = dly_ff[DLY-1].pm;

      s4_in       = '0;
      s4_in.fin   = 1'b1;
      s4_in.cmp   = sd.cmp;

      su  = '0;
      qs  = '0;
      pms = '0;
      dz_m = '0;

      case (sd.act)
         ACT_ADD, ACT_SUB: begin
            s4_in.sign = sd.add_sign;
            if (sd.add_pass) begin
               s4_in.sign  = sd.pass_sign;
               s4_in.fin_e = sd.pass_e;
               s4_in.fin_m = sd.pass_m;
            end else if (sd.add_e >= {1'b0, SPEC}) begin
               s4_in.fin_e = SPEC;
            end else begin
               s4_in.fin   = 1'b0;
               s4_in.nrm_e = sd.add_e[E-1:0];
               s4_in.nrm_m = sd.add_mag;
               s4_in.zfix  = 1'b1;
            end
         end
         ACT_MUL: begin
            s4_in.sign = sd.sx;
            su  = {UW{1'b0}} - sd.mul_u;
            pms = pm >> su;
            if (sd.any_zero) begin
               s4_in.fin_e = '0;
            end else if (sd.any_inf) begin
               s4_in.fin_e = SPEC;
            end else if (sd.any_nan) begin
               s4_in.fin_e = SPEC;
               s4_in.fin_m = QNAN;
            end else if (sd.mul_ovf) begin
               s4_in.fin_e = SPEC;
            end else if ($signed(sd.mul_u) < 0) begin
               // underflow: right-shifted subnormal
               s4_in.fin_m = pms;
            end else begin
               s4_in.fin   = 1'b0;
               s4_in.nrm_e = sd.mul_u[E-1:0];
               s4_in.nrm_m = pm;
            end
         end
         ACT_DIV: begin
            s4_in.sign = sd.sx;
            su = {UW{1'b0}} - sd.div_u;
            qs = div_q >> su;
            // a zero divisor yields an endless run of ones above the quotient
            for (int j = 0; j < M; j++) begin
               dz_m[j] = (int'(su) + j) < 128;
            end
            if (sd.a_zero && sd.b_zero) begin
               s4_in.fin_e = SPEC;
               s4_in.fin_m = QNAN;
            end else if (sd.b_inf || sd.a_zero) begin
               s4_in.fin_e = '0;
            end else if (sd.b_zero || sd.a_inf) begin
               s4_in.fin_e = SPEC;
            end else if (sd.any_nan) begin
               s4_in.fin_e = SPEC;
               s4_in.fin_m = QNAN;
            end else if ($signed(sd.div_u) < 0) begin
               s4_in.fin_m = sd.dz ? dz_m : qs[M-1:0];
            end else if (sd.div_u >= {2'b00, SPEC}) begin
               s4_in.fin_e = SPEC;
            end else begin
               s4_in.fin   = 1'b0;
               s4_in.nrm_e = sd.div_u[E-1:0];
               s4_in.nrm_m = sd.dz ? {M{1'b1}} : div_q[M-1:0];
            end
         end
         default: begin
            // compare and unused codes leave the arithmetic fields zero
            s4_in.fin = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= dly_vld_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      s4_ff <= s4_in;
   end

   // ---------------------------------------------------------------- stage 5: leading zero count
   post_type      s5_ff;
   logic [SW-1:0] sh_in, sh_ff;
   logic          s5_vld_ff;

   always_comb begin
      logic [LZW-1:0] lz;
      lz = LZW'(M);
      for (int i = 0; i < M; i++) begin
         if (s4_ff.nrm_m[i]) begin
            lz = LZW'(M - 1 - i);
         end
      end
      // stop shifting once the exponent reaches zero
      if (SW'(s4_ff.nrm_e) < SW'(lz)) begin
         sh_in = SW'(s4_ff.nrm_e);
      end else begin
         sh_in = SW'(lz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_ff <= s4_ff;
      sh_ff <= sh_in;
   end

   // ---------------------------------------------------------------- stage 6: shift and output register
   logic          out_vld_ff;
   logic          out_sign_ff;
   logic [E-1:0]  out_exp_ff, out_exp_in;
   logic [M-1:0]  out_mant_ff, out_mant_in;
   cmp_flags_type out_cmp_ff;

   always_comb begin
      logic [M-1:0] m_sh;
      m_sh = s5_ff.nrm_m << sh_ff;
      if (s5_ff.fin) begin
         out_exp_in  = s5_ff.fin_e;
         out_mant_in = s5_ff.fin_m;
      end else begin
         out_mant_in = m_sh;
         out_exp_in  = s5_ff.nrm_e - sh_ff[E-1:0];
         if (s5_ff.zfix && m_sh == '0) begin
            out_exp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_sign_ff <= s5_ff.sign;
      out_exp_ff  <= out_exp_in;
      out_mant_ff <= out_mant_in;
      out_cmp_ff  <= s5_ff.cmp;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_sign = out_sign_ff;
   assign rsp_result_exp  = out_exp_ff;
   assign rsp_result_mant = out_mant_ff;
   assign rsp_greater     = out_cmp_ff.greater;
   assign rsp_less        = out_cmp_ff.less;
   assign rsp_equal       = out_cmp_ff.equal;
   assign rsp_unordered   = out_cmp_ff.unordered;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result beat missing at fixed latency");

   a_align: assert property (@(posedge clock) disable iff (reset)
      div_vld == dly_vld_ff[DLY-1])
      else $error("quotient and side data out of step");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_greater, rsp_less, rsp_equal, rsp_unordered}))
      else $error("more than one compare flag set");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_greater || rsp_less || rsp_equal || rsp_unordered))
         |-> (!rsp_result_sign && rsp_result_exp == '0 && rsp_result_mant == '0))
      else $error("compare beat carries arithmetic fields");
`endif

endmodule

// File: tb/testbench.sv
// self-checking testbench for float_add_mul_div_compare_unit
// depends on famdc_pkg and the unit; a built-in predictor computes every expected beat
module testbench;
   import famdc_pkg::*;

   localparam int EW = 8;
   localparam int MW = 24;
   localparam logic [EW-1:0] EXP_SPECIAL = '1;
   localparam logic [EW-1:0] EXP_BIAS = 8'd127;
   localparam logic [MW-1:0] QUIET_NAN = 24'h400000;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic          s;
      logic [EW-1:0] e;
      logic [MW-1:0] m;
   } fp_operand;

   typedef struct packed {
      logic          sign;
      logic [EW-1:0] exponent;
      logic [MW-1:0] mantissa;
      cmp_flags_type flags;
   } fpu_outcome;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_action = '0;
   logic req_lhs_sign = 0, req_rhs_sign = 0;
   logic [EW-1:0] req_lhs_exp = '0, req_rhs_exp = '0;
   logic [MW-1:0] req_lhs_mant = '0, req_rhs_mant = '0;
   logic rsp_valid, rsp_result_sign, rsp_greater, rsp_less, rsp_equal, rsp_unordered;
   logic [EW-1:0] rsp_result_exp;
   logic [MW-1:0] rsp_result_mant;

   fpu_outcome pending_results[$];
   int error_count = 0;
   int cycle_count = 0;
   bit idle_enable = 1;

   float_add_mul_div_compare_unit i_dut (.*);

   // free-running clock, period 20
   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case results never drain
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic bit is_special(fp_operand x);
      return x.e == EXP_SPECIAL;
   endfunction
   function automatic bit is_nan(fp_operand x);
      return is_special(x) && x.m != 0;
   endfunction
   function automatic bit is_inf(fp_operand x);
      return is_special(x) && x.m == 0;
   endfunction
   function automatic bit is_zero(fp_operand x);
      return x.e == 0 && x.m == 0;
   endfunction

   // shift left until the top bit is set, but never below exponent zero
   function automatic fp_operand normalize(fp_operand x);
      int lz;
      int sh;
      lz = 0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (x.m[i]) break;
         lz++;
      end
      sh = (x.e < lz) ? int'(x.e) : lz;
      x.m = x.m << sh;
      x.e = x.e - EW'(sh);
      return x;
   endfunction

   function automatic fp_operand float_sum(fp_operand a, fp_operand b);
      fp_operand big, lit, r;
      logic [MW-1:0] lm, mag;
      logic [MW:0] total;
      logic carry;
      logic [EW:0] re;
      big = (a.e < b.e) ? b : a;
      lit = (a.e < b.e) ? a : b;
      lm = lit.m >> (big.e - lit.e);
      carry = 0;
      if (big.s == lit.s) begin
         total = {1'b0, big.m} + {1'b0, lm};
         carry = total[MW];
         mag = total[MW-1:0];
         if (carry) mag = {1'b1, mag[MW-1:1]};
         r.s = big.s;
      end else if (big.m >= lm) begin
         mag = big.m - lm;
         r.s = big.s;
      end else begin
         mag = lm - big.m;
         r.s = lit.s;
      end
      if (mag == 0) r.s = 0;
      re = {1'b0, big.e} + carry;
      if (re >= EXP_SPECIAL) begin
         r.e = EXP_SPECIAL;
         r.m = '0;
      end else begin
         r.e = re[EW-1:0];
         r.m = mag;
         r = normalize(r);
         if (r.m == 0) r.e = '0;
      end
      // special operands pass through, first one wins
      if (is_special(b)) r = b;
      if (is_special(a)) r = a;
      return r;
   endfunction

   function automatic fp_operand float_product(fp_operand a, fp_operand b);
      fp_operand r;
      int esum, u;
      logic [2*MW-1:0] prod;
      logic [MW-1:0] pm;
      esum = a.e + b.e;
      u = esum - EXP_BIAS;
      if (esum >= int'(EXP_SPECIAL) + EXP_BIAS) begin
         r.e = EXP_SPECIAL;
         r.m = '0;
      end else begin
         prod = {{MW{1'b0}}, a.m} * {{MW{1'b0}}, b.m};
         pm = prod[2*MW-1:MW];
         if (u < 0) begin
            r.m = pm >> (-u);
            r.e = '0;
         end else begin
            r.m = pm;
            r.e = EW'(u);
            r = normalize(r);
         end
      end
      if (is_nan(a) || is_nan(b)) begin r.e = EXP_SPECIAL; r.m = QUIET_NAN; end
      if (is_inf(a) || is_inf(b)) begin r.e = EXP_SPECIAL; r.m = '0; end
      if (is_zero(a) || is_zero(b)) begin r.e = '0; r.m = '0; end
      r.s = a.s ^ b.s;
      return r;
   endfunction

   function automatic fp_operand float_quotient(fp_operand a, fp_operand b);
      fp_operand r;
      int u;
      logic [127:0] num, q, qs;
      u = int'(a.e) - int'(b.e) + EXP_BIAS + 1;
      num = {104'b0, a.m} << (MW - 1);
      // zero divisor mantissa yields an all-ones quotient
      q = (b.m == 0) ? '1 : num / {104'b0, b.m};
      if (u < 0) begin
         qs = q >> (-u);
         r.m = qs[MW-1:0];
         r.e = '0;
      end else if (u >= int'(EXP_SPECIAL)) begin
         r.e = EXP_SPECIAL;
         r.m = '0;
      end else begin
         r.m = q[MW-1:0];
         r.e = EW'(u);
         r = normalize(r);
      end
      if (is_nan(a) || is_nan(b)) begin r.e = EXP_SPECIAL; r.m = QUIET_NAN; end
      if (is_zero(b) || is_inf(a)) begin r.e = EXP_SPECIAL; r.m = '0; end
      if (is_inf(b) || is_zero(a)) begin r.e = '0; r.m = '0; end
      if (is_zero(a) && is_zero(b)) begin r.e = EXP_SPECIAL; r.m = QUIET_NAN; end
      r.s = a.s ^ b.s;
      return r;
   endfunction

   function automatic bit ordered_above(fp_operand a, fp_operand b);
      bit mag_gt, mag_lt;
      if (a.s != b.s) return a.s < b.s;
      mag_gt = (a.e > b.e) || (a.e == b.e && a.m > b.m);
      mag_lt = (a.e < b.e) || (a.e == b.e && a.m < b.m);
      return a.s ? mag_lt : mag_gt;
   endfunction

   function automatic fpu_outcome predict_fpu(logic [2:0] act, fp_operand a, fp_operand b);
      fpu_outcome o;
      fp_operand r;
      bit nan, both_zero;
      o = '0;
      r = '0;
      case (act)
         ACT_ADD: r = float_sum(a, b);
         ACT_SUB: begin
            b.s = ~b.s;
            r = float_sum(a, b);
         end
         ACT_MUL: r = float_product(a, b);
         ACT_DIV: r = float_quotient(a, b);
         ACT_CMP: begin
            nan = is_nan(a) || is_nan(b);
            both_zero = is_zero(a) && is_zero(b);
            o.flags.greater = !nan && !both_zero && ordered_above(a, b);
            o.flags.less = !nan && !both_zero && ordered_above(b, a);
            o.flags.equal = both_zero || (!nan && a == b);
            o.flags.unordered = nan;
         end
         default: ;
      endcase
      o.sign = r.s;
      o.exponent = r.e;
      o.mantissa = r.m;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // result checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      fpu_outcome want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_sign !== want.sign) begin
               $error("result_sign exp %0h got %0h", want.sign, rsp_result_sign);
               error_count++;
            end
            if (rsp_result_exp !== want.exponent) begin
               $error("result_exp exp %0h got %0h", want.exponent, rsp_result_exp);
               error_count++;
            end
            if (rsp_result_mant !== want.mantissa) begin
               $error("result_mant exp %0h got %0h", want.mantissa, rsp_result_mant);
               error_count++;
            end
            if (rsp_greater !== want.flags.greater) begin
               $error("greater exp %0h got %0h", want.flags.greater, rsp_greater);
               error_count++;
            end
            if (rsp_less !== want.flags.less) begin
               $error("less exp %0h got %0h", want.flags.less, rsp_less);
               error_count++;
            end
            if (rsp_equal !== want.flags.equal) begin
               $error("equal exp %0h got %0h", want.flags.equal, rsp_equal);
               error_count++;
            end
            if (rsp_unordered !== want.flags.unordered) begin
               $error("unordered exp %0h got %0h", want.flags.unordered, rsp_unordered);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // drive one beat at the falling edge; busy follows reset, which is already low here,
   // so its value here is the one the next rising edge sees
   task automatic send_op(logic [2:0] act, fp_operand a, fp_operand b);
      if (idle_enable && $urandom_range(99) < 15) begin
         @(negedge clock);
         start <= 0;
      end
      @(negedge clock);
      start <= 1;
      req_action <= act;
      req_lhs_sign <= a.s;
      req_lhs_exp <= a.e;
      req_lhs_mant <= a.m;
      req_rhs_sign <= b.s;
      req_rhs_exp <= b.e;
      req_rhs_mant <= b.m;
      while (busy) @(negedge clock);
      pending_results.push_back(predict_fpu(act, a, b));
      @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic fp_operand make_fp(logic s, logic [EW-1:0] e, logic [MW-1:0] m);
      return '{s: s, e: e, m: m};
   endfunction

   // operands weighted toward edges: specials, zeros, subnormals, near bias
   function automatic fp_operand random_operand();
      fp_operand x;
      x.s = 1'($urandom_range(1));
      case ($urandom_range(9))
         0: x.e = EXP_SPECIAL;
         1: x.e = '0;
         2: x.e = EW'($urandom_range(3));
         3: x.e = EXP_SPECIAL - EW'($urandom_range(3));
         4, 5: x.e = EW'(EXP_BIAS - 12 + $urandom_range(24));
         default: x.e = EW'($urandom);
      endcase
      case ($urandom_range(7))
         0: x.m = '0;
         1: x.m = '1;
         2: x.m = 24'h800000;
         3: x.m = MW'($urandom_range(255));
         default: x.m = {1'b1, 23'($urandom)};
      endcase
      if ($urandom_range(9) == 0) x.m = MW'($urandom);
      return x;
   endfunction

   task automatic test_add_sub();
      fp_operand inf_p, nan_q, one, maxn;
      inf_p = make_fp(0, EXP_SPECIAL, 0);
      nan_q = make_fp(1, EXP_SPECIAL, 24'h123456);
      one = make_fp(0, EXP_BIAS, 24'h800000);
      maxn = make_fp(0, 8'hfe, '1);
      send_op(ACT_ADD, one, one);
      send_op(ACT_SUB, one, one);                 // zero sum
      send_op(ACT_ADD, maxn, maxn);               // carry into infinity
      send_op(ACT_ADD, nan_q, inf_p);             // first special wins
      send_op(ACT_SUB, one, inf_p);               // pass-through with flipped sign
      send_op(ACT_ADD, make_fp(1, 0, 24'h000003), make_fp(0, 1, 24'h800000));
   endtask

   task automatic test_mul_div();
      fp_operand zero, inf_n, nan_q, one, tiny, maxn;
      zero = make_fp(0, 0, 0);
      inf_n = make_fp(1, EXP_SPECIAL, 0);
      nan_q = make_fp(0, EXP_SPECIAL, 24'h000001);
      one = make_fp(0, EXP_BIAS, 24'h800000);
      tiny = make_fp(1, 1, 24'hffffff);
      maxn = make_fp(0, 8'hfe, '1);
      send_op(ACT_MUL, maxn, maxn);               // exponent overflow
      send_op(ACT_MUL, tiny, tiny);               // underflow to subnormal
      send_op(ACT_MUL, nan_q, inf_n);
      send_op(ACT_MUL, inf_n, zero);              // zero wins over infinity
      send_op(ACT_DIV, one, zero);
      send_op(ACT_DIV, zero, zero);               // both zero gives quiet nan
      send_op(ACT_DIV, inf_n, inf_n);
      send_op(ACT_DIV, one, make_fp(0, 8'h40, 0)); // zero divisor mantissa
      send_op(ACT_DIV, tiny, maxn);
   endtask

   task automatic test_compare_and_unused();
      fp_operand one;
      one = make_fp(0, EXP_BIAS, 24'h800000);
      send_op(ACT_CMP, make_fp(0, 0, 0), make_fp(1, 0, 0)); // plus and minus zero
      send_op(ACT_CMP, one, one);
      send_op(ACT_CMP, make_fp(1, 8'h80, 24'h900000), make_fp(1, 8'h80, 24'h800000));
      send_op(ACT_CMP, one, make_fp(0, EXP_SPECIAL, 24'h000010));
      send_op(3'd5, one, one);
      send_op(3'd7, make_fp(1, '1, '1), make_fp(1, '1, '1));
   endtask

   task automatic test_random_mix(int count);
      logic [2:0] act;
      for (int n = 0; n < count; n++) begin
         // a stretch with no gaps from the sender
         idle_enable = !(n >= 400 && n < 700);
         act = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
         send_op(act, random_operand(), random_operand());
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_add_sub();
      test_mul_div();
      wait_drained();
      test_compare_and_unused();
      test_random_mix(1800);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/famdc_pkg.sv
rtl/famdc_divider.sv
rtl/float_add_mul_div_compare_unit.sv
tb/testbench.sv
